/* rtl/b32h_pkg.sv */
package b32h_pkg;

    localparam int unsigned LabelMaxDef = 63;
    localparam int unsigned LabelW      = 6;
    localparam int unsigned ResultCap   = 9;
    localparam int unsigned ResW        = 4;
    localparam int unsigned IdxW        = 3;
    localparam int unsigned GroupLen    = 8;

    localparam logic [7:0] CharPad = 8'h3D;
    localparam logic [7:0] CharDot = 8'h2E;

    typedef enum logic {
        ModeBase32 = 1'b0,
        ModeHex    = 1'b1
    } t_mode;

    typedef struct packed {
        logic [2:0][7:0] sym;
        logic [1:0]      n_sym;
        logic [2:0]      n_pad;
        logic            last;
    } t_job;

    function automatic logic [7:0] sym32(input logic [4:0] v);
        logic [7:0] r;
        if (v < 5'd26) begin
            r = 8'h61 + {3'b000, v};
        end else begin
            r = 8'h32 + {3'b000, v} - 8'd26;
        end
        return r;
    endfunction

    function automatic logic [7:0] sym16(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'b0000, v};
        end else begin
            r = 8'h61 + {4'b0000, v} - 8'd10;
        end
        return r;
    endfunction

endpackage

/* rtl/b32h_ifs.sv */
interface b32h_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
    modport mon(input valid, input data_byte, input last_byte, input ready);
endinterface

interface b32h_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source(output valid, output out_char, output last_char, input ready);
    modport sink(input valid, input out_char, input last_char, output ready);
    modport mon(input valid, input out_char, input last_char, input ready);
endinterface

interface b32h_cfg_if;
    logic valid;
    logic ready;
    logic encode_mode;

    modport source(output valid, output encode_mode, input ready);
    modport sink(input valid, input encode_mode, output ready);
    modport mon(input valid, input encode_mode, input ready);
endinterface

/* rtl/b32h_front.sv */
module b32h_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    b32h_in_if.sink          i_in,
    b32h_cfg_if.sink         i_cfg,
    input  logic             i_full,
    output logic             o_push,
    output b32h_pkg::t_job   o_job
);

    b32h_pkg::t_mode r_mode, n_mode;
    logic [3:0]      r_lb, n_lb;
    logic [2:0]      r_lc, n_lc;
    logic [2:0]      r_grp, n_grp;

    logic [11:0] acc;
    logic [3:0]  nbits;
    logic [3:0]  sh0;
    logic [3:0]  sh1;
    logic        two;
    logic [4:0]  s0;
    logic [4:0]  s1;
    logic [2:0]  rem;
    logic [4:0]  mask5;
    logic [3:0]  rem_bits;
    logic        flush;
    logic [8:0]  fsh;
    logic [4:0]  fsym;
    logic [1:0]  nsym;
    logic [2:0]  g1;
    logic [2:0]  pad_raw;
    logic [3:0]  cap;
    logic [2:0]  pad;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;
    assign o_push      = i_in.valid && !i_full;

    always_comb begin
        acc      = {r_lb, i_in.data_byte};
        nbits    = {1'b0, r_lc} + 4'd8;
        two      = nbits >= 4'd10;
        sh0      = nbits - 4'd5;
        sh1      = nbits - 4'd10;
        s0       = 5'(acc >> sh0);
        s1       = 5'(acc >> sh1);
        rem      = two ? 3'(sh1) : 3'(sh0);
        mask5    = (5'd1 << rem) - 5'd1;
        rem_bits = acc[3:0] & mask5[3:0];
        flush    = i_in.last_byte && (rem != 3'd0);
        fsh      = {5'b00000, rem_bits} << (3'd5 - rem);
        fsym     = fsh[4:0];
        nsym     = (two ? 2'd2 : 2'd1) + {1'b0, flush};
        g1       = r_grp + {1'b0, nsym};
        pad_raw  = 3'd0 - g1;
        cap      = 4'(b32h_pkg::GroupLen) - {2'b00, nsym};
        pad      = ({1'b0, pad_raw} > cap) ? cap[2:0] : pad_raw;

        o_job.last = i_in.last_byte;
        n_lb       = r_lb;
        n_lc       = r_lc;
        n_grp      = r_grp;

        if (r_mode == b32h_pkg::ModeHex) begin
            o_job.sym[0] = b32h_pkg::sym16(i_in.data_byte[7:4]);
            o_job.sym[1] = b32h_pkg::sym16(i_in.data_byte[3:0]);
            o_job.sym[2] = b32h_pkg::CharPad;
            o_job.n_sym  = 2'd2;
            o_job.n_pad  = 3'd0;
        end else begin
            o_job.sym[0] = b32h_pkg::sym32(s0);
            o_job.sym[1] = b32h_pkg::sym32(two ? s1 : fsym);
            o_job.sym[2] = b32h_pkg::sym32(fsym);
            o_job.n_sym  = nsym;
            o_job.n_pad  = i_in.last_byte ? pad : 3'd0;
            n_lb         = rem_bits;
            n_lc         = rem;
            n_grp        = g1;
        end

        if (i_in.last_byte) begin
            n_lb  = 4'd0;
            n_lc  = 3'd0;
            n_grp = 3'd0;
        end

        n_mode = r_mode;
        if (i_cfg.valid) begin
            n_mode = b32h_pkg::t_mode'(i_cfg.encode_mode);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= b32h_pkg::ModeBase32;
            r_lb   <= 4'd0;
            r_lc   <= 3'd0;
            r_grp  <= 3'd0;
        end else begin
            r_mode <= n_mode;
            if (o_push) begin
                r_lb  <= n_lb;
                r_lc  <= n_lc;
                r_grp <= n_grp;
            end
        end
    end

endmodule

/* rtl/b32h_queue.sv */
module b32h_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b32h_pkg::t_job   i_job,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output b32h_pkg::t_job   o_job
);

    b32h_pkg::t_job r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_cnt, n_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rptr];

    always_comb begin
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

endmodule

/* rtl/b32h_back.sv */
module b32h_back #(
    parameter int unsigned LABEL_MAX = b32h_pkg::LabelMaxDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  b32h_pkg::t_job   i_job,
    output logic             o_pop,
    b32h_out_if.source       o_out
);

    localparam int unsigned LW = b32h_pkg::LabelW;
    localparam int unsigned RW = b32h_pkg::ResW;
    localparam int unsigned XW = b32h_pkg::IdxW;
    localparam logic [LW-1:0] LabelLimit = LW'(LABEL_MAX);
    localparam logic [RW-1:0] ResLimit   = RW'(b32h_pkg::ResultCap);

    logic [LW-1:0] r_label, n_label;
    logic [RW-1:0] r_res, n_res;
    logic [XW-1:0] r_idx, n_idx;
    logic          r_out_valid;
    logic [7:0]    r_char;
    logic          r_fin;

    logic [XW:0]   last_idx;
    logic          is_sym;
    logic [7:0]    cur;
    logic          need_dot;
    logic          slot_ok;
    logic          out_free;
    logic          step;
    logic          emit;
    logic          end_item;
    logic [7:0]    emit_char;
    logic          emit_fin;

    assign o_out.valid     = r_out_valid;
    assign o_out.out_char  = r_char;
    assign o_out.last_char = r_fin;
    assign o_pop           = end_item;

    always_comb begin
        last_idx  = (XW+1)'({2'b00, i_job.n_sym}) + (XW+1)'({1'b0, i_job.n_pad})
                    - (XW+1)'(1);
        is_sym    = r_idx < {1'b0, i_job.n_sym};
        cur       = is_sym ? i_job.sym[r_idx[1:0]] : b32h_pkg::CharPad;
        need_dot  = r_label >= LabelLimit;
        slot_ok   = r_res < ResLimit;
        out_free  = !r_out_valid || o_out.ready;
        step      = i_job_valid && (out_free || !slot_ok);
        emit      = step && slot_ok;
        end_item  = step && !need_dot && ({1'b0, r_idx} == last_idx);
        emit_char = need_dot ? b32h_pkg::CharDot : cur;
        emit_fin  = !need_dot && i_job.last && ({1'b0, r_idx} == last_idx);

        n_label = r_label;
        n_res   = r_res;
        n_idx   = r_idx;
        if (step) begin
            n_label = need_dot ? '0 : r_label + LW'(1);
            if (emit) begin
                n_res = r_res + RW'(1);
            end
            if (!need_dot) begin
                n_idx = r_idx + XW'(1);
            end
            if (end_item) begin
                n_idx = '0;
                n_res = '0;
                if (i_job.last) begin
                    n_label = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= emit_char;
            r_fin  <= emit_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_label     <= '0;
            r_res       <= '0;
            r_idx       <= '0;
        end else begin
            r_label <= n_label;
            r_res   <= n_res;
            r_idx   <= n_idx;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/base32_hex_label_encoder.sv */
// Byte-stream to text encoder, base32 (lowercase, '=' padded) or lowercase hex,
// with the text cut into labels of at most LABEL_MAX characters separated by '.'.
// Channels: i_in carries data_byte and last_byte, o_out carries out_char and
// last_char; both use valid/ready and move one transaction per cycle at most.
// i_cfg writes encode_mode (0 base32, 1 hex); write it only while idle.
// The front end converts an accepted byte in the same cycle into a job of up
// to eight characters and pushes it into a two-entry queue. The back end
// emits one character, pad or dot per cycle, while o_out is not stalled, into
// an output register. With the queue empty, an accepted byte's job is written
// into the queue and its first character then into the output register.
// Throughput: one output character per cycle while o_out is ready; a byte
// yields two characters for hex, one or two for base32, up to eight on a
// final base32 byte with padding, plus one dot at each label end. The output
// port sets the pace. A message ends on the character flagged by last_char.
// Reset clears the mode to base32, the partial symbol, group and label counts.
// When o_out stalls, the output register holds, the queue fills and i_in
// ready drops; nothing is lost.
module base32_hex_label_encoder #(
    parameter int unsigned LABEL_MAX = b32h_pkg::LabelMaxDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    b32h_in_if.sink      i_in,
    b32h_cfg_if.sink     i_cfg,
    b32h_out_if.source   o_out
);

    logic           push;
    logic           pop;
    logic           full;
    logic           job_valid;
    b32h_pkg::t_job fe_job;
    b32h_pkg::t_job be_job;

    b32h_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (fe_job)
    );

    b32h_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (fe_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (job_valid),
        .o_job   (be_job)
    );

    b32h_back #(
        .LABEL_MAX (LABEL_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (be_job),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

/* rtl/b32h_checker.sv */
module b32h_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_ready,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_char,
    input  logic       i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
            && $stable(i_out_last))
        else $error("output transaction changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_last_not_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> i_out_char != b32h_pkg::CharDot)
        else $error("separator flagged as final character");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config channel not ready");

endmodule

bind base32_hex_label_encoder b32h_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_ready (i_cfg.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_last  (o_out.last_char)
);
